// ----- rtl/core/usf_pkg.sv -----
// Shared types for the UTF-8 sanitizing filter: channel payloads and the
// packet that carries the bytes of one input from the front end to the back end.
// No dependencies.
package usf_pkg;

    localparam int PKT_BYTES = 4;
    localparam int PKT_CNT_W = 3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       run_last;
        logic       text_end;
        logic [7:0] out_count;
    } t_out;

    // Bytes released by one input; count zero with last set is a bare end marker.
    typedef struct packed {
        logic [PKT_BYTES-1:0][7:0] data_bytes;
        logic [PKT_CNT_W-1:0]      count;
        logic [7:0]                base;
        logic                      last;
    } t_pkt;

endpackage

// ----- rtl/core/usf_front.sv -----
// Front end: takes input bytes, keeps the four-byte sequence window, checks
// sequences and pushes the released bytes as one packet. Uses usf_pkg.
module usf_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  usf_pkg::t_in   i_data,
    input  logic           i_cfg_we,
    input  logic [7:0]     i_cfg_wdata,
    input  logic           i_full,
    output logic           o_push,
    output usf_pkg::t_pkt  o_pkt
);

    localparam logic [7:0]  MAX_RESET   = 8'hFF;
    localparam logic [20:0] CP_TOP      = 21'h10FFFF;
    localparam logic [20:0] SURR_LO     = 21'h00D800;
    localparam logic [20:0] SURR_HI     = 21'h00DFFF;
    localparam logic [20:0] CTRL_HI     = 21'h00001F;
    localparam logic [20:0] DEL_CP      = 21'h00007F;
    localparam logic [20:0] C1_LO       = 21'h000080;
    localparam logic [20:0] C1_HI       = 21'h00009F;
    localparam logic [20:0] BIDI_A_LO   = 21'h00202A;
    localparam logic [20:0] BIDI_A_HI   = 21'h00202E;
    localparam logic [20:0] BIDI_B_LO   = 21'h002066;
    localparam logic [20:0] BIDI_B_HI   = 21'h002069;
    localparam logic [20:0] MIN_TWO     = 21'h000080;
    localparam logic [20:0] MIN_THREE   = 21'h000800;
    localparam logic [20:0] MIN_FOUR    = 21'h010000;

    logic [3:0][7:0] r_win;
    logic [1:0]      r_held;
    logic [7:0]      r_emit;
    logic            r_halted;
    logic [7:0]      r_max;

    logic [3:0][7:0] n_win;
    logic [2:0]      n_cnt;
    logic [7:0]      n_emit;
    logic            n_halted;
    logic [3:0][7:0] n_ob;
    logic [2:0]      n_nout;
    logic            accept;

    function automatic logic [2:0] seq_len(input logic [7:0] b);
        if (b[7] == 1'b0)               return 3'd1;
        else if (b[7:5] == 3'b110)      return 3'd2;
        else if (b[7:4] == 4'b1110)     return 3'd3;
        else if (b[7:3] == 5'b11110)    return 3'd4;
        else                            return 3'd0;
    endfunction

    function automatic logic [20:0] code_point(input logic [3:0][7:0] w,
                                               input logic [2:0] need);
        logic [20:0] cp;
        case (need)
            3'd1:    cp = {13'd0, w[0]};
            3'd2:    cp = {10'd0, w[0][4:0], w[1][5:0]};
            3'd3:    cp = {5'd0, w[0][3:0], w[1][5:0], w[2][5:0]};
            3'd4:    cp = {w[0][2:0], w[1][5:0], w[2][5:0], w[3][5:0]};
            default: cp = '0;
        endcase
        return cp;
    endfunction

    function automatic logic point_rejected(input logic [20:0] cp, input logic [2:0] need);
        logic rej;
        rej = (need == 3'd2 && cp < MIN_TWO) ||
              (need == 3'd3 && cp < MIN_THREE) ||
              (need == 3'd4 && cp < MIN_FOUR) ||
              (cp > CP_TOP) ||
              (cp >= SURR_LO && cp <= SURR_HI) ||
              (cp <= CTRL_HI) || (cp == DEL_CP) ||
              (cp >= C1_LO && cp <= C1_HI) ||
              (cp >= BIDI_A_LO && cp <= BIDI_A_HI) ||
              (cp >= BIDI_B_LO && cp <= BIDI_B_HI);
        return rej;
    endfunction

    // Drop k bytes off the front of the window; vacated slots keep stale data.
    function automatic logic [3:0][7:0] drop_front(input logic [3:0][7:0] w,
                                                   input logic [2:0] k);
        logic [3:0][7:0] r;
        logic [2:0]      src;
        r = w;
        for (int j = 0; j < 4; j++) begin
            src = 3'(j) + k;
            if (src < 3'd4) begin
                r[j] = w[src[1:0]];
            end
        end
        return r;
    endfunction

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    // Resolve the window: each pass drops, emits or stops on the oldest lead.
    always_comb begin
        logic [2:0]  need;
        logic        done;
        logic        bad;
        logic [20:0] cp;
        n_win    = r_win;
        n_cnt    = {1'b0, r_held};
        n_emit   = r_emit;
        n_halted = r_halted;
        n_ob     = '0;
        n_nout   = '0;
        done     = r_halted;
        need     = '0;
        bad      = 1'b0;
        cp       = '0;
        if (!r_halted) begin
            n_win[r_held] = i_data.in_byte;
            n_cnt         = n_cnt + 3'd1;
        end
        for (int it = 0; it < 4; it++) begin
            if (!done) begin
                if (n_cnt == 3'd0) begin
                    done = 1'b1;
                end else begin
                    need = seq_len(n_win[0]);
                    bad  = 1'b0;
                    for (int k = 1; k < 4; k++) begin
                        if (3'(k) < need && n_win[k][7:6] != 2'b10) begin
                            bad = 1'b1;
                        end
                    end
                    cp = code_point(n_win, need);
                    if (need == 3'd0) begin
                        n_win = drop_front(n_win, 3'd1);
                        n_cnt = n_cnt - 3'd1;
                    end else if (n_cnt < need) begin
                        if (i_data.in_last) begin
                            n_halted = 1'b1;
                        end
                        done = 1'b1;
                    end else if (bad) begin
                        // Broken sequence: drop the lead only, rescan the rest.
                        n_win = drop_front(n_win, 3'd1);
                        n_cnt = n_cnt - 3'd1;
                    end else if (point_rejected(cp, need)) begin
                        n_win = drop_front(n_win, need);
                        n_cnt = n_cnt - need;
                    end else if ({1'b0, n_emit} + 9'(need) > {1'b0, r_max}) begin
                        n_halted = 1'b1;
                        done     = 1'b1;
                    end else begin
                        for (int k = 0; k < 4; k++) begin
                            if (3'(k) < need) begin
                                n_ob[2'(n_nout + 3'(k))] = n_win[k];
                            end
                        end
                        n_nout = n_nout + need;
                        n_emit = n_emit + 8'(need);
                        n_win  = drop_front(n_win, need);
                        n_cnt  = n_cnt - need;
                    end
                end
            end
        end
        if (n_halted) begin
            n_cnt = 3'd0;
        end
    end

    assign o_push           = accept && (n_nout != 3'd0 || i_data.in_last);
    assign o_pkt.data_bytes = n_ob;
    assign o_pkt.count      = n_nout;
    assign o_pkt.base       = r_emit;
    assign o_pkt.last       = i_data.in_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held   <= '0;
            r_emit   <= '0;
            r_halted <= 1'b0;
            r_max    <= MAX_RESET;
        end else begin
            if (i_cfg_we) begin
                r_max <= i_cfg_wdata;
            end
            if (accept) begin
                if (i_data.in_last) begin
                    r_held   <= '0;
                    r_emit   <= '0;
                    r_halted <= 1'b0;
                end else begin
                    r_held   <= n_cnt[1:0];
                    r_emit   <= n_emit;
                    r_halted <= n_halted;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_win <= n_win;
        end
    end

endmodule

// ----- rtl/core/usf_queue.sv -----
// Short packet queue between the front end and the back end.
// Uses usf_pkg for the packet type.
module usf_queue #(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  usf_pkg::t_pkt i_pkt,
    input  logic          i_pop,
    output usf_pkg::t_pkt o_head,
    output logic          o_full,
    output logic          o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    usf_pkg::t_pkt    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(DEPTH - 1)) begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    assign o_head  = r_mem[r_rd];
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= bump(r_wr);
            end
            if (i_pop) begin
                r_rd <= bump(r_rd);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_pkt;
        end
    end

endmodule

// ----- rtl/core/usf_back.sv -----
// Back end: walks the head packet one byte at a time into the output register.
// Uses usf_pkg for the packet and result types.
module usf_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  usf_pkg::t_pkt i_head,
    input  logic          i_empty,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output usf_pkg::t_out o_data
);

    logic          r_valid;
    usf_pkg::t_out r_out;
    logic [1:0]    r_idx;
    usf_pkg::t_out n_res;
    logic          load;

    assign load = !i_empty && (!r_valid || i_ready);

    always_comb begin
        if (i_head.count == '0) begin
            n_res.data_byte = '0;
            n_res.has_byte  = 1'b0;
            n_res.run_last  = 1'b1;
            n_res.text_end  = 1'b1;
            n_res.out_count = i_head.base;
        end else begin
            n_res.data_byte = i_head.data_bytes[r_idx];
            n_res.has_byte  = 1'b1;
            n_res.run_last  = ({1'b0, r_idx} + 3'd1 == i_head.count);
            n_res.text_end  = i_head.last && n_res.run_last;
            n_res.out_count = i_head.base + 8'(r_idx) + 8'd1;
        end
    end

    assign o_pop   = load && n_res.run_last;
    assign o_valid = r_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= n_res.run_last ? 2'd0 : r_idx + 2'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_res;
        end
    end

endmodule

// ----- rtl/core/utf8_sanitizing_filter.sv -----
// UTF-8 sanitizing filter, top level.
// Input channel i_valid/o_ready/i_data carries one text byte per transfer with a
// last flag. Output channel o_valid/i_ready/o_data carries one result per
// transfer: a kept byte, or a bare end marker when the last byte releases nothing.
// i_cfg_we/i_cfg_wdata write max_bytes (reset 255); write it between texts.
// The first result of an item passes the packet queue, then the output register.
// Input takes one byte per cycle while the queue is not full. An item that
// releases k bytes gives k results: the back end moves one byte per cycle from
// the queue to the output register unless the receiver stalls. The front end
// resolves a full four-byte window in the cycle of the transfer.
// When the receiver stalls, the output register holds, the packet queue fills
// (QUEUE_DEPTH packets), then o_ready drops.
// Reset (synchronous, active low) empties the window, queue and output register.
// Uses usf_pkg, usf_front, usf_queue, usf_back.
module utf8_sanitizing_filter #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  usf_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output usf_pkg::t_out o_data,
    input  logic          i_cfg_we,
    input  logic [7:0]    i_cfg_wdata
);

    logic          q_push;
    logic          q_pop;
    logic          q_full;
    logic          q_empty;
    usf_pkg::t_pkt q_in;
    usf_pkg::t_pkt q_head;

    usf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_full      (q_full),
        .o_push      (q_push),
        .o_pkt       (q_in)
    );

    usf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_pkt   (q_in),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    usf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (q_head),
        .i_empty (q_empty),
        .o_pop   (q_pop),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

    a_end_is_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.text_end) |-> o_data.run_last)
        else $error("text end without run last");

    a_bare_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.has_byte) |-> (o_data.text_end && o_data.data_byte == 8'd0))
        else $error("bare marker outside text end");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.has_byte) |-> (o_data.out_count != 8'd0))
        else $error("byte result with zero count");

endmodule

// ----- bench/tb_utf8_sanitizing_filter.sv -----
// Self-checking testbench for utf8_sanitizing_filter: directed and random texts,
// each byte predicted in-bench and compared with every output transfer.
// Depends on usf_pkg and the utf8_sanitizing_filter RTL.
`timescale 1ns / 100ps

module tb_utf8_sanitizing_filter;

    localparam int          WATCHDOG_CYCLES = 2000;
    localparam int          SETTLE_CYCLES   = 6;
    localparam int          HOLD_CYCLES     = 120;
    localparam int unsigned CP_MAX          = 32'h10FFFF;
    localparam int unsigned SURR_LO         = 32'hD800;
    localparam int unsigned SURR_HI         = 32'hDFFF;
    localparam int unsigned EMBED_LO        = 32'h202A;
    localparam int unsigned EMBED_HI        = 32'h202E;
    localparam int unsigned ISOLATE_LO      = 32'h2066;
    localparam int unsigned ISOLATE_HI      = 32'h2069;
    localparam int unsigned ASCII_CTRL_HI   = 32'h1F;
    localparam int unsigned ASCII_DEL       = 32'h7F;
    localparam int unsigned LATIN_CTRL_LO   = 32'h80;
    localparam int unsigned LATIN_CTRL_HI   = 32'h9F;
    localparam logic [7:0]  MAX_BYTES_RESET = 8'd255;

    logic          i_clk       = 1'b0;
    logic          i_rst_n     = 1'b0;
    logic          i_valid     = 1'b0;
    logic          o_ready;
    usf_pkg::t_in  i_data      = '0;
    logic          o_valid;
    logic          i_ready     = 1'b0;
    usf_pkg::t_out o_data;
    logic          i_cfg_we    = 1'b0;
    logic [7:0]    i_cfg_wdata = '0;

    utf8_sanitizing_filter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Filter state as the bench sees it
    logic [7:0] win_bytes [4];
    int         win_fill;
    int         text_emitted;
    bit         text_halted;
    logic [7:0] max_bytes_model = MAX_BYTES_RESET;

    usf_pkg::t_out results_due [$];
    logic [7:0]    text_buf [$];

    int errors        = 0;
    int bytes_sent    = 0;
    int texts_sent    = 0;
    int results_seen  = 0;
    int input_stalls  = 0;
    int hold_reqs     = 0;
    bit no_gaps       = 1'b0;

    function automatic int lead_length(logic [7:0] lead);
        if (lead[7] == 1'b0) return 1;
        if (lead[7:5] == 3'b110) return 2;
        if (lead[7:4] == 4'b1110) return 3;
        if (lead[7:3] == 5'b11110) return 4;
        return 0;
    endfunction

    function automatic bit point_rejected(int unsigned cp, int len);
        if (len == 2 && cp < 32'h80) return 1'b1;
        if (len == 3 && cp < 32'h800) return 1'b1;
        if (len == 4 && cp < 32'h10000) return 1'b1;
        if (cp > CP_MAX || (cp >= SURR_LO && cp <= SURR_HI)) return 1'b1;
        if (cp <= ASCII_CTRL_HI || cp == ASCII_DEL) return 1'b1;
        if (cp >= LATIN_CTRL_LO && cp <= LATIN_CTRL_HI) return 1'b1;
        if (cp >= EMBED_LO && cp <= EMBED_HI) return 1'b1;
        if (cp >= ISOLATE_LO && cp <= ISOLATE_HI) return 1'b1;
        return 1'b0;
    endfunction

    function automatic void shift_window(int k);
        if (k >= win_fill) begin
            win_fill = 0;
            return;
        end
        for (int i = 0; i + k < win_fill; i++) win_bytes[i] = win_bytes[i + k];
        win_fill -= k;
    endfunction

    // Work out the results of one accepted byte and queue them
    function automatic void sanitize_byte(logic [7:0] b, logic last);
        usf_pkg::t_out batch [$];
        usf_pkg::t_out r;
        int            need;
        bit            bad;
        int unsigned   cp;

        if (!text_halted) begin
            win_bytes[win_fill] = b;
            win_fill++;
            while (win_fill > 0 && !text_halted) begin
                need = lead_length(win_bytes[0]);
                if (need == 0) begin
                    shift_window(1);
                    continue;
                end
                if (win_fill < need) begin
                    if (last) text_halted = 1'b1;
                    break;
                end
                bad = 1'b0;
                for (int k = 1; k < need; k++)
                    if (win_bytes[k][7:6] != 2'b10) bad = 1'b1;
                if (bad) begin
                    // drop only the lead, rescan from the next held byte
                    shift_window(1);
                    continue;
                end
                case (need)
                    1:       cp = 32'(win_bytes[0]);
                    2:       cp = 32'(win_bytes[0][4:0]);
                    3:       cp = 32'(win_bytes[0][3:0]);
                    default: cp = 32'(win_bytes[0][2:0]);
                endcase
                for (int k = 1; k < need; k++) cp = (cp << 6) | 32'(win_bytes[k][5:0]);
                if (point_rejected(cp, need)) begin
                    shift_window(need);
                    continue;
                end
                if (text_emitted + need > int'(max_bytes_model)) begin
                    text_halted = 1'b1;
                    break;
                end
                for (int k = 0; k < need; k++) begin
                    text_emitted++;
                    r = '{data_byte: win_bytes[k], has_byte: 1'b1, run_last: 1'b0,
                          text_end: 1'b0, out_count: text_emitted[7:0]};
                    batch.push_back(r);
                end
                shift_window(need);
            end
            if (text_halted) win_fill = 0;
        end

        if (last) begin
            if (batch.size() == 0) begin
                r = '{data_byte: 8'h00, has_byte: 1'b0, run_last: 1'b0,
                      text_end: 1'b0, out_count: text_emitted[7:0]};
                batch.push_back(r);
            end
            batch[batch.size() - 1].text_end = 1'b1;
        end
        if (batch.size() > 0) batch[batch.size() - 1].run_last = 1'b1;
        foreach (batch[i]) results_due.push_back(batch[i]);

        if (last) begin
            win_fill     = 0;
            text_emitted = 0;
            text_halted  = 1'b0;
        end
    endfunction

    // Encode cp into len bytes, overlong or out of range if asked
    function automatic void put_cp(int unsigned cp, int len);
        logic [20:0] v;
        v = cp[20:0];
        case (len)
            1: text_buf.push_back(v[7:0]);
            2: begin
                text_buf.push_back({3'b110, v[10:6]});
                text_buf.push_back({2'b10, v[5:0]});
            end
            3: begin
                text_buf.push_back({4'b1110, v[15:12]});
                text_buf.push_back({2'b10, v[11:6]});
                text_buf.push_back({2'b10, v[5:0]});
            end
            default: begin
                text_buf.push_back({5'b11110, v[20:18]});
                text_buf.push_back({2'b10, v[17:12]});
                text_buf.push_back({2'b10, v[11:6]});
                text_buf.push_back({2'b10, v[5:0]});
            end
        endcase
    endfunction

    function automatic int unsigned good_cp(int len);
        if (len == 2) return $urandom_range(32'h100, 32'h7FF);
        if (len == 3) return $urandom_range(32'h3000, 32'h9FFF);
        return $urandom_range(32'h10000, CP_MAX);
    endfunction

    function automatic void add_random_piece();
        int          kind;
        int          len;
        int          base;
        int unsigned cp;
        logic [7:0]  b;

        kind = $urandom_range(0, 99);
        if (kind < 30) begin
            put_cp($urandom_range(32'h20, 32'h7E), 1);
        end else if (kind < 36) begin
            put_cp(($urandom_range(0, 3) == 0) ? ASCII_DEL : $urandom_range(0, ASCII_CTRL_HI), 1);
        end else if (kind < 50) begin
            put_cp($urandom_range(32'hA0, 32'h7FF), 2);
        end else if (kind < 62) begin
            cp = $urandom_range(32'h800, 32'hFFFF);
            if (cp >= SURR_LO && cp <= SURR_HI) cp -= 32'h1000;
            put_cp(cp, 3);
        end else if (kind < 70) begin
            put_cp($urandom_range(32'h10000, CP_MAX), 4);
        end else if (kind < 74) begin
            case ($urandom_range(0, 3))
                0:       put_cp($urandom_range(LATIN_CTRL_LO, LATIN_CTRL_HI), 2);
                1:       put_cp($urandom_range(EMBED_LO, EMBED_HI), 3);
                2:       put_cp($urandom_range(ISOLATE_LO, ISOLATE_HI), 3);
                default: put_cp($urandom_range(SURR_LO, SURR_HI), 3);
            endcase
        end else if (kind < 78) begin
            len = $urandom_range(2, 4);
            put_cp($urandom_range(0, (len == 2) ? 32'h7F : (len == 3) ? 32'h7FF : 32'hFFFF), len);
        end else if (kind < 80) begin
            put_cp($urandom_range(CP_MAX + 1, 32'h1FFFFF), 4);
        end else if (kind < 86) begin
            // break one continuation byte of a good sequence
            len  = $urandom_range(2, 4);
            base = text_buf.size();
            put_cp(good_cp(len), len);
            b = 8'($urandom);
            if (b[7:6] == 2'b10) b[6] = 1'b1;
            text_buf[base + $urandom_range(1, len - 1)] = b;
        end else if (kind < 90) begin
            text_buf.push_back($urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hBF))
                                                    : 8'($urandom_range(8'hF8, 8'hFF)));
        end else begin
            text_buf.push_back(8'($urandom));
        end
    endfunction

    // Lead plus fewer continuation bytes than it needs
    function automatic void add_cut_sequence();
        int len;
        len = $urandom_range(2, 4);
        case (len)
            2:       text_buf.push_back({3'b110, 5'($urandom)});
            3:       text_buf.push_back({4'b1110, 4'($urandom)});
            default: text_buf.push_back({5'b11110, 3'($urandom)});
        endcase
        repeat ($urandom_range(0, len - 2))
            text_buf.push_back(($urandom_range(0, 4) == 0) ? 8'($urandom)
                                                           : {2'b10, 6'($urandom)});
    endfunction

    function automatic void build_random_text();
        text_buf.delete();
        repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 8))
            add_random_piece();
        if ($urandom_range(0, 9) == 0) add_cut_sequence();
    endfunction

    function automatic int gap_length();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 30);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = (no_gaps || $urandom_range(0, 99) < 65) ? 0 : gap_length();
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_data  <= '{in_byte: b, in_last: last};
        do @(posedge i_clk); while (!o_ready);
        sanitize_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_text();
        foreach (text_buf[i]) send_byte(text_buf[i], i == text_buf.size() - 1);
        texts_sent++;
    endtask

    // Drop valid and let every expected result drain
    task automatic drain_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_max_bytes(input logic [7:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        max_bytes_model = value;
    endtask

    task automatic test_directed_text();
        // ASCII, DEL, lone continuation, 0xFF, two-byte, overlong, embedding control,
        // four-byte, broken three-byte, surrogate, above range, cut at text end
        text_buf = {8'h41, 8'h7F, 8'h80, 8'hFF, 8'hC3, 8'hA9, 8'hC0, 8'h80,
                    8'hE2, 8'h80, 8'hAA, 8'hF0, 8'h9F, 8'h98, 8'h80, 8'hE2,
                    8'h41, 8'hED, 8'hA0, 8'h80, 8'hF4, 8'h90, 8'h80, 8'h80,
                    8'hE2, 8'h82};
        send_text();
        drain_idle();
    endtask

    task automatic test_overflow();
        set_max_bytes(8'd2);
        text_buf = {8'hC3, 8'hA9, 8'h41};
        send_text();
        drain_idle();
    endtask

    task automatic test_zero_budget();
        set_max_bytes(8'd0);
        text_buf = {8'h41};
        send_text();
        drain_idle();
    endtask

    // Receiver stalls long while the sender keeps offering two-byte characters
    task automatic test_backpressure();
        set_max_bytes(MAX_BYTES_RESET);
        text_buf.delete();
        repeat (20) put_cp($urandom_range(32'hA0, 32'h7FF), 2);
        no_gaps = 1'b1;
        hold_reqs++;
        send_text();
        drain_idle();
        no_gaps = 1'b0;
    endtask

    task automatic test_random_phase(input logic [7:0] limit, input int budget, input bit steady);
        int start;
        set_max_bytes(limit);
        no_gaps = steady;
        start   = bytes_sent;
        while (bytes_sent - start < budget) begin
            build_random_text();
            send_text();
        end
        drain_idle();
        no_gaps = 1'b0;
    endtask

    initial begin : receiver
        int hold_left;
        int low_left;
        int seen_reqs;
        hold_left = 0;
        low_left  = 0;
        seen_reqs = 0;
        forever begin
            @(negedge i_clk);
            if (hold_reqs != seen_reqs) begin
                seen_reqs = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (low_left > 0) begin
                low_left--;
                i_ready <= 1'b0;
            end else if (!no_gaps && $urandom_range(0, 99) < 15) begin
                low_left = gap_length() - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        usf_pkg::t_out want;
        if (i_rst_n) begin
            if (i_valid && !o_ready) input_stalls++;
            if (o_valid && i_ready) begin
                results_seen++;
                if (results_due.size() == 0) begin
                    $error("result with none expected: %p", o_data);
                    errors++;
                end else begin
                    want = results_due.pop_front();
                    if (o_data.data_byte != want.data_byte) begin
                        $error("data_byte: expected %02h, got %02h", want.data_byte,
                               o_data.data_byte);
                        errors++;
                    end
                    if (o_data.has_byte != want.has_byte) begin
                        $error("has_byte: expected %0b, got %0b", want.has_byte, o_data.has_byte);
                        errors++;
                    end
                    if (o_data.run_last != want.run_last) begin
                        $error("run_last: expected %0b, got %0b", want.run_last, o_data.run_last);
                        errors++;
                    end
                    if (o_data.text_end != want.text_end) begin
                        $error("text_end: expected %0b, got %0b", want.text_end, o_data.text_end);
                        errors++;
                    end
                    if (o_data.out_count != want.out_count) begin
                        $error("out_count: expected %0d, got %0d", want.out_count,
                               o_data.out_count);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_CYCLES) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) quiet = 0;
            else quiet++;
        end
        $display("no transfer for %0d cycles, %0d results outstanding",
                 WATCHDOG_CYCLES, results_due.size());
        $display("status: fail");
        $finish;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_text();
        test_overflow();
        test_zero_budget();
        test_backpressure();
        test_random_phase(MAX_BYTES_RESET, 90, 1'b0);
        test_random_phase(8'd12, 80, 1'b0);
        test_random_phase(8'd0, 20, 1'b0);
        test_random_phase(8'($urandom_range(1, 254)), 90, 1'b1);
        test_random_phase(MAX_BYTES_RESET, 80, 1'b0);

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("sent %0d bytes in %0d texts over several max_bytes settings, checked %0d results",
                 bytes_sent, texts_sent, results_seen);
        $display("input held off by a full filter for %0d cycles, %0d mismatches",
                 input_stalls, errors);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- utf8_sanitizing_filter.f -----
rtl/core/usf_pkg.sv
rtl/core/usf_front.sv
rtl/core/usf_queue.sv
rtl/core/usf_back.sv
rtl/core/utf8_sanitizing_filter.sv
bench/tb_utf8_sanitizing_filter.sv
